// File: rtl/multirotor_motor_mixer_assert.svh
// assertion macros for the motor mixer, sampled on clock and disabled in reset
`ifndef MULTIROTOR_MOTOR_MIXER_ASSERT_SVH
`define MULTIROTOR_MOTOR_MIXER_ASSERT_SVH

// same-cycle implication
`define MMM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// fixed-latency implication
`define MMM_ASSERT_LATENCY(label, ante, n, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

// File: rtl/mmm_pkg.sv
package mmm_pkg;

   localparam int NUM_MOTORS = 6;

   // motor and register values
   typedef logic [10:0] value_type;
   // mixed motor sums before limiting
   typedef logic signed [13:0] sum_type;
   // sums after excess removal
   typedef logic signed [14:0] adj_type;

   typedef enum logic [2:0] {
      FRAME_BI        = 3'd0,
      FRAME_TRI       = 3'd1,
      FRAME_QUAD_PLUS = 3'd2,
      FRAME_QUAD_X    = 3'd3,
      FRAME_Y4        = 3'd4,
      FRAME_Y6        = 3'd5,
      FRAME_HEX_PLUS  = 3'd6,
      FRAME_HEX_X     = 3'd7
   } frame_type_type;

   typedef enum logic [2:0] {
      CSR_FRAME_TYPE        = 3'd0,
      CSR_YAW_REVERSED      = 3'd1,
      CSR_MIN_THROTTLE      = 3'd2,
      CSR_MAX_THROTTLE      = 3'd3,
      CSR_MIN_COMMAND       = 3'd4,
      CSR_MIN_CHECK         = 3'd5,
      CSR_STOP_AT_LOW_STICK = 3'd6
   } csr_index_type;

   localparam frame_type_type FRAME_RESET        = FRAME_QUAD_X;
   localparam value_type      MIN_THROTTLE_RESET = 11'd1150;
   localparam value_type      MAX_THROTTLE_RESET = 11'd1850;
   localparam value_type      MIN_COMMAND_RESET  = 11'd1000;
   localparam value_type      MIN_CHECK_RESET    = 11'd1100;

   // base of the yaw correction limit
   localparam logic signed [11:0] YAW_LIMIT_BASE = 12'sd100;

   // floor(a/3) == (a * DIV3_RECIP) >> DIV3_SHIFT for a below 2**17
   localparam logic [15:0] DIV3_RECIP = 16'd43691;
   localparam int          DIV3_SHIFT = 17;

endpackage

// File: rtl/multirotor_motor_mixer.sv
// multirotor motor mixer: one control sample in, six motor values out
// the result strobe comes out of the last of 7 register stages, the first of which takes start
// throughput: one sample per cycle except while busy after reset; the receiver cannot hold results off
// reset: synchronous, active high; clears the pipeline valid bits and loads the register
//   defaults; busy is a registered copy of reset, and csr_ready is low while busy is high
module multirotor_motor_mixer (
   input  logic                 clock,
   input  logic                 reset,
   // sample channel
   input  logic                 start,
   output logic                 busy,
   input  mmm_pkg::value_type   req_throttle_command,
   input  logic signed [9:0]    req_yaw_stick,
   input  logic signed [10:0]   req_roll_correction,
   input  logic signed [10:0]   req_pitch_correction,
   input  logic signed [10:0]   req_yaw_correction,
   input  mmm_pkg::value_type   req_throttle_stick,
   input  logic                 req_armed,
   // result channel
   output logic                 rsp_strobe,
   output mmm_pkg::value_type   rsp_motor_0,
   output mmm_pkg::value_type   rsp_motor_1,
   output mmm_pkg::value_type   rsp_motor_2,
   output mmm_pkg::value_type   rsp_motor_3,
   output mmm_pkg::value_type   rsp_motor_4,
   output mmm_pkg::value_type   rsp_motor_5,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  mmm_pkg::value_type   csr_wdata
);
   import mmm_pkg::*;

   `include "multirotor_motor_mixer_assert.svh"

   // number of motors a frame drives
   function automatic logic [2:0] motor_count(frame_type_type frame);
      logic [2:0] n;
      case (frame)
         FRAME_BI:                                n = 3'd2;
         FRAME_TRI:                               n = 3'd3;
         FRAME_QUAD_PLUS, FRAME_QUAD_X, FRAME_Y4: n = 3'd4;
         default:                                 n = 3'd6;
      endcase
      return n;
   endfunction

   // magnitude and sign back to a signed sum term
   function automatic sum_type apply_sign(value_type mag, logic neg);
      sum_type v;
      v = $signed({3'b000, mag});
      return neg ? -v : v;
   endfunction

   function automatic sum_type max2(sum_type a, sum_type b);
      return (a > b) ? a : b;
   endfunction

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   frame_type_type frame_type_ff;
   logic           yaw_reversed_ff;
   value_type      min_throttle_ff;
   value_type      max_throttle_ff;
   value_type      min_command_ff;
   value_type      min_check_ff;
   logic           stop_at_low_stick_ff;
   logic           busy_ff;

   logic csr_write;
   logic pipe_active;

   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff & ~pipe_active;
   assign csr_write = csr_valid & csr_ready;

   // register writes, taken only while the pipeline is idle
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_type_ff        <= FRAME_RESET;
         yaw_reversed_ff      <= 1'b0;
         min_throttle_ff      <= MIN_THROTTLE_RESET;
         max_throttle_ff      <= MAX_THROTTLE_RESET;
         min_command_ff       <= MIN_COMMAND_RESET;
         min_check_ff         <= MIN_CHECK_RESET;
         stop_at_low_stick_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FRAME_TYPE:        frame_type_ff        <= frame_type_type'(csr_wdata[2:0]);
            CSR_YAW_REVERSED:      yaw_reversed_ff      <= csr_wdata[0];
            CSR_MIN_THROTTLE:      min_throttle_ff      <= csr_wdata;
            CSR_MAX_THROTTLE:      max_throttle_ff      <= csr_wdata;
            CSR_MIN_COMMAND:       min_command_ff       <= csr_wdata;
            CSR_MIN_CHECK:         min_check_ff         <= csr_wdata;
            CSR_STOP_AT_LOW_STICK: stop_at_low_stick_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // busy only right after reset
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // ------------------------------------------------------------------
   // pipeline valid bits
   // ------------------------------------------------------------------
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_strobe_ff;
   logic v0_in;

   assign v0_in = start & ~busy_ff;

   // any beat still in a stage that reads the registers
   assign pipe_active = v0_ff | v1_ff | v2_ff | v3_ff | v4_ff | v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         v5_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v0_ff         <= v0_in;
         v1_ff         <= v0_ff;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
         v5_ff         <= v4_ff;
         rsp_strobe_ff <= v5_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;

   // ------------------------------------------------------------------
   // stage 0: input beat capture
   // ------------------------------------------------------------------
   value_type          thr0_ff;
   logic signed [9:0]  ystick0_ff;
   logic signed [10:0] roll0_ff;
   logic signed [10:0] pitch0_ff;
   logic signed [10:0] yaw0_ff;
   value_type          stick0_ff;
   logic               armed0_ff;

   always_ff @(posedge clock) begin
      if (v0_in) begin
         thr0_ff    <= req_throttle_command;
         ystick0_ff <= req_yaw_stick;
         roll0_ff   <= req_roll_correction;
         pitch0_ff  <= req_pitch_correction;
         yaw0_ff    <= req_yaw_correction;
         stick0_ff  <= req_throttle_stick;
         armed0_ff  <= req_armed;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: yaw limit and sign, correction magnitudes
   // ------------------------------------------------------------------
   logic [9:0]         ystick_abs;
   logic signed [11:0] yaw_lim;
   logic signed [11:0] yaw_ext;
   logic signed [11:0] yaw_lim_c;
   logic signed [11:0] yaw1_in;
   value_type          roll_abs1_in;
   value_type          pitch_abs1_in;
   logic [12:0]        roll7_1_in;
   logic [12:0]        pitch7_1_in;

   assign ystick_abs    = ystick0_ff[9] ? (~ystick0_ff + 10'd1) : ystick0_ff;
   assign yaw_lim       = $signed({2'b00, ystick_abs}) + YAW_LIMIT_BASE;
   assign yaw_ext       = $signed({yaw0_ff[10], yaw0_ff});
   assign roll_abs1_in  = roll0_ff[10]  ? (~roll0_ff  + 11'd1) : roll0_ff;
   assign pitch_abs1_in = pitch0_ff[10] ? (~pitch0_ff + 11'd1) : pitch0_ff;
   assign roll7_1_in    = 13'({2'b00, roll_abs1_in, 3'b000} - {5'b00000, roll_abs1_in});
   assign pitch7_1_in   = 13'({2'b00, pitch_abs1_in, 3'b000} - {5'b00000, pitch_abs1_in});

   // frames with four or more motors limit yaw, then apply the direction sign
   always_comb begin
      yaw_lim_c = yaw_ext;
      if (motor_count(frame_type_ff) > 3'd3) begin
         if (yaw_ext > yaw_lim) begin
            yaw_lim_c = yaw_lim;
         end else if (yaw_ext < -yaw_lim) begin
            yaw_lim_c = -yaw_lim;
         end
      end
      yaw1_in = yaw_reversed_ff ? -yaw_lim_c : yaw_lim_c;
   end

   value_type          thr1_ff;
   value_type          stick1_ff;
   logic               armed1_ff;
   logic signed [11:0] yaw1_ff;
   value_type          roll_abs1_ff;
   value_type          pitch_abs1_ff;
   logic               roll_neg1_ff;
   logic               pitch_neg1_ff;
   logic [12:0]        roll7_1_ff;
   logic [12:0]        pitch7_1_ff;

   always_ff @(posedge clock) begin
      thr1_ff       <= thr0_ff;
      stick1_ff     <= stick0_ff;
      armed1_ff     <= armed0_ff;
      yaw1_ff       <= yaw1_in;
      roll_abs1_ff  <= roll_abs1_in;
      pitch_abs1_ff <= pitch_abs1_in;
      roll_neg1_ff  <= roll0_ff[10];
      pitch_neg1_ff <= pitch0_ff[10];
      roll7_1_ff    <= roll7_1_in;
      pitch7_1_ff   <= pitch7_1_in;
   end

   // ------------------------------------------------------------------
   // stage 2: fractional coefficient magnitudes (truncating toward zero)
   // ------------------------------------------------------------------
   logic [28:0] prod43;
   logic [28:0] prod23;

   // divide by three through the reciprocal
   assign prod43 = 29'({pitch_abs1_ff, 2'b00}) * 29'(DIV3_RECIP);
   assign prod23 = 29'({pitch_abs1_ff, 1'b0}) * 29'(DIV3_RECIP);

   value_type          thr2_ff;
   value_type          stick2_ff;
   logic               armed2_ff;
   logic signed [11:0] yaw2_ff;
   logic               roll_neg2_ff;
   logic               pitch_neg2_ff;
   value_type          r1_2_ff, r78_2_ff, r12_2_ff;
   value_type          p1_2_ff, p43_2_ff, p23_2_ff, p78_2_ff, p12_2_ff;

   always_ff @(posedge clock) begin
      thr2_ff       <= thr1_ff;
      stick2_ff     <= stick1_ff;
      armed2_ff     <= armed1_ff;
      yaw2_ff       <= yaw1_ff;
      roll_neg2_ff  <= roll_neg1_ff;
      pitch_neg2_ff <= pitch_neg1_ff;
      r1_2_ff       <= roll_abs1_ff;
      r78_2_ff      <= {1'b0, roll7_1_ff[12:3]};
      r12_2_ff      <= {1'b0, roll_abs1_ff[10:1]};
      p1_2_ff       <= pitch_abs1_ff;
      p43_2_ff      <= 11'(prod43 >> DIV3_SHIFT);
      p23_2_ff      <= 11'(prod23 >> DIV3_SHIFT);
      p78_2_ff      <= {1'b0, pitch7_1_ff[12:3]};
      p12_2_ff      <= {1'b0, pitch_abs1_ff[10:1]};
   end

   // ------------------------------------------------------------------
   // stage 3: per-frame mixing
   // ------------------------------------------------------------------
   sum_type thr_s, y_s;
   sum_type r_s, r78_s, r12_s;
   sum_type p_s, p43_s, p23_s, p78_s, p12_s;
   sum_type m3_in [NUM_MOTORS];

   assign thr_s = $signed({3'b000, thr2_ff});
   assign y_s   = $signed({{2{yaw2_ff[11]}}, yaw2_ff});
   assign r_s   = apply_sign(r1_2_ff,  roll_neg2_ff);
   assign r78_s = apply_sign(r78_2_ff, roll_neg2_ff);
   assign r12_s = apply_sign(r12_2_ff, roll_neg2_ff);
   assign p_s   = apply_sign(p1_2_ff,  pitch_neg2_ff);
   assign p43_s = apply_sign(p43_2_ff, pitch_neg2_ff);
   assign p23_s = apply_sign(p23_2_ff, pitch_neg2_ff);
   assign p78_s = apply_sign(p78_2_ff, pitch_neg2_ff);
   assign p12_s = apply_sign(p12_2_ff, pitch_neg2_ff);

   always_comb begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
         m3_in[i] = '0;
      end
      case (frame_type_ff)
         FRAME_BI: begin
            m3_in[0] = thr_s + r_s;
            m3_in[1] = thr_s - r_s;
         end
         FRAME_TRI: begin
            m3_in[0] = thr_s + p43_s;
            m3_in[1] = thr_s - r_s - p23_s;
            m3_in[2] = thr_s + r_s - p23_s;
         end
         FRAME_QUAD_PLUS: begin
            m3_in[0] = thr_s + p_s - y_s;
            m3_in[1] = thr_s - r_s + y_s;
            m3_in[2] = thr_s + r_s + y_s;
            m3_in[3] = thr_s - p_s - y_s;
         end
         FRAME_QUAD_X: begin
            m3_in[0] = thr_s - r_s + p_s - y_s;
            m3_in[1] = thr_s - r_s - p_s + y_s;
            m3_in[2] = thr_s + r_s + p_s + y_s;
            m3_in[3] = thr_s + r_s - p_s - y_s;
         end
         FRAME_Y4: begin
            m3_in[0] = thr_s + p_s - y_s;
            m3_in[1] = thr_s - r_s - p_s;
            m3_in[2] = thr_s + p_s + y_s;
            m3_in[3] = thr_s + r_s - p_s;
         end
         FRAME_Y6: begin
            m3_in[0] = thr_s + p43_s + y_s;
            m3_in[1] = thr_s - r_s - p23_s - y_s;
            m3_in[2] = thr_s + r_s - p23_s - y_s;
            m3_in[3] = thr_s + p43_s - y_s;
            m3_in[4] = thr_s - r_s - p23_s + y_s;
            m3_in[5] = thr_s + r_s - p23_s + y_s;
         end
         FRAME_HEX_PLUS: begin
            m3_in[0] = thr_s - r78_s + p12_s + y_s;
            m3_in[1] = thr_s - r78_s - p12_s - y_s;
            m3_in[2] = thr_s + r78_s + p12_s + y_s;
            m3_in[3] = thr_s + r78_s - p12_s - y_s;
            m3_in[4] = thr_s - p_s + y_s;
            m3_in[5] = thr_s + p_s - y_s;
         end
         FRAME_HEX_X: begin
            m3_in[0] = thr_s - r12_s + p78_s + y_s;
            m3_in[1] = thr_s - r12_s - p78_s + y_s;
            m3_in[2] = thr_s + r12_s + p78_s - y_s;
            m3_in[3] = thr_s + r12_s - p78_s - y_s;
            m3_in[4] = thr_s - r_s - y_s;
            m3_in[5] = thr_s + r_s + y_s;
         end
         default: ;
      endcase
   end

   sum_type   m3_ff [NUM_MOTORS];
   value_type stick3_ff;
   logic      armed3_ff;

   always_ff @(posedge clock) begin
      m3_ff     <= m3_in;
      stick3_ff <= stick2_ff;
      armed3_ff <= armed2_ff;
   end

   // ------------------------------------------------------------------
   // stage 4: pairwise maximum over the used motors
   // ------------------------------------------------------------------
   logic [2:0] n_motors;
   sum_type    pmax01_in, pmax23_in, pmax45_in;

   assign n_motors = motor_count(frame_type_ff);

   // unused slots take motor 0, which never changes the maximum
   always_comb begin
      pmax01_in = max2(m3_ff[0], m3_ff[1]);
      if (n_motors > 3'd3) begin
         pmax23_in = max2(m3_ff[2], m3_ff[3]);
      end else if (n_motors > 3'd2) begin
         pmax23_in = m3_ff[2];
      end else begin
         pmax23_in = m3_ff[0];
      end
      pmax45_in = (n_motors > 3'd4) ? max2(m3_ff[4], m3_ff[5]) : m3_ff[0];
   end

   sum_type   m4_ff [NUM_MOTORS];
   sum_type   pmax01_ff, pmax23_ff, pmax45_ff;
   value_type stick4_ff;
   logic      armed4_ff;

   always_ff @(posedge clock) begin
      m4_ff     <= m3_ff;
      pmax01_ff <= pmax01_in;
      pmax23_ff <= pmax23_in;
      pmax45_ff <= pmax45_in;
      stick4_ff <= stick3_ff;
      armed4_ff <= armed3_ff;
   end

   // ------------------------------------------------------------------
   // stage 5: overall maximum and excess over max throttle
   // ------------------------------------------------------------------
   sum_type mx;
   sum_type max_ext;
   sum_type excess5_in;

   assign mx         = max2(max2(pmax01_ff, pmax23_ff), pmax45_ff);
   assign max_ext    = $signed({3'b000, max_throttle_ff});
   assign excess5_in = (mx > max_ext) ? (mx - max_ext) : '0;

   sum_type   m5_ff [NUM_MOTORS];
   sum_type   excess5_ff;
   value_type stick5_ff;
   logic      armed5_ff;

   always_ff @(posedge clock) begin
      m5_ff      <= m4_ff;
      excess5_ff <= excess5_in;
      stick5_ff  <= stick4_ff;
      armed5_ff  <= armed4_ff;
   end

   // ------------------------------------------------------------------
   // stage 6: excess removal, clamp, stick and arming overrides
   // ------------------------------------------------------------------
   adj_type   adj_val [NUM_MOTORS];
   adj_type   min_adj, max_adj;
   logic      low_stick;
   value_type idle_val;
   value_type motor_in [NUM_MOTORS];

   assign min_adj   = $signed({4'b0000, min_throttle_ff});
   assign max_adj   = $signed({4'b0000, max_throttle_ff});
   assign low_stick = stick5_ff < min_check_ff;
   assign idle_val  = stop_at_low_stick_ff ? min_command_ff : min_throttle_ff;

   always_comb begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
         adj_val[i] = $signed({m5_ff[i][13], m5_ff[i]})
                    - $signed({excess5_ff[13], excess5_ff});
         if (3'(i) >= n_motors) begin
            motor_in[i] = '0;
         end else if (!armed5_ff) begin
            motor_in[i] = min_command_ff;
         end else if (low_stick) begin
            motor_in[i] = idle_val;
         end else if (adj_val[i] < min_adj) begin
            motor_in[i] = min_throttle_ff;
         end else if (adj_val[i] > max_adj) begin
            motor_in[i] = max_throttle_ff;
         end else begin
            motor_in[i] = adj_val[i][10:0];
         end
      end
   end

   value_type motor_ff [NUM_MOTORS];

   always_ff @(posedge clock) begin
      motor_ff <= motor_in;
   end

   assign rsp_motor_0 = motor_ff[0];
   assign rsp_motor_1 = motor_ff[1];
   assign rsp_motor_2 = motor_ff[2];
   assign rsp_motor_3 = motor_ff[3];
   assign rsp_motor_4 = motor_ff[4];
   assign rsp_motor_5 = motor_ff[5];

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // every accepted beat leaves the pipeline after the fixed latency
   `MMM_ASSERT_LATENCY(a_fixed_latency, start && !busy, 7, rsp_strobe, "result beat missing")
   // a disarmed sample always drives min command on the first motor
   `MMM_ASSERT_NEXT(a_disarmed_idle, v5_ff && !armed5_ff, rsp_motor_0 == $past(min_command_ff), "disarmed motor not at min command")
   // excess removal never leaves motor 0 above max throttle
   `MMM_ASSERT_NEXT(a_excess_removed, v4_ff, adj_val[0] <= $signed($past(max_adj)), "excess not removed")

endmodule

// File: tb/mixer_checker.sv
`timescale 1ns / 100ps

module mixer_checker (
   input  logic                 clock,
   input  logic                 reset,
   // sample channel
   input  logic                 start,
   input  logic                 busy,
   input  mmm_pkg::value_type   req_throttle_command,
   input  logic signed [9:0]    req_yaw_stick,
   input  logic signed [10:0]   req_roll_correction,
   input  logic signed [10:0]   req_pitch_correction,
   input  logic signed [10:0]   req_yaw_correction,
   input  mmm_pkg::value_type   req_throttle_stick,
   input  logic                 req_armed,
   // result channel
   input  logic                 rsp_strobe,
   input  mmm_pkg::value_type   rsp_motor_0,
   input  mmm_pkg::value_type   rsp_motor_1,
   input  mmm_pkg::value_type   rsp_motor_2,
   input  mmm_pkg::value_type   rsp_motor_3,
   input  mmm_pkg::value_type   rsp_motor_4,
   input  mmm_pkg::value_type   rsp_motor_5,
   // register write channel
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  mmm_pkg::value_type   csr_wdata,
   // status for the stimulus side
   output int                   fail_count,
   output int                   pending
);

   import mmm_pkg::*;

   localparam int MAX_PRINTS = 40;

   typedef logic [5:0][10:0] motor_set_t;

   // mixing coefficients, fractions are multiply then truncating divide
   typedef enum int {
      C_0, C_P1, C_M1, C_P43, C_M23, C_P78, C_M78, C_P12, C_M12
   } coef_id_t;

   // per frame, per motor: roll, pitch, yaw coefficient
   coef_id_t mix_tab [8][6][3] = '{
      '{'{C_P1, C_0, C_0}, '{C_M1, C_0, C_0}, '{C_0, C_0, C_0},
        '{C_0, C_0, C_0}, '{C_0, C_0, C_0}, '{C_0, C_0, C_0}},
      '{'{C_0, C_P43, C_0}, '{C_M1, C_M23, C_0}, '{C_P1, C_M23, C_0},
        '{C_0, C_0, C_0}, '{C_0, C_0, C_0}, '{C_0, C_0, C_0}},
      '{'{C_0, C_P1, C_M1}, '{C_M1, C_0, C_P1}, '{C_P1, C_0, C_P1},
        '{C_0, C_M1, C_M1}, '{C_0, C_0, C_0}, '{C_0, C_0, C_0}},
      '{'{C_M1, C_P1, C_M1}, '{C_M1, C_M1, C_P1}, '{C_P1, C_P1, C_P1},
        '{C_P1, C_M1, C_M1}, '{C_0, C_0, C_0}, '{C_0, C_0, C_0}},
      '{'{C_0, C_P1, C_M1}, '{C_M1, C_M1, C_0}, '{C_0, C_P1, C_P1},
        '{C_P1, C_M1, C_0}, '{C_0, C_0, C_0}, '{C_0, C_0, C_0}},
      '{'{C_0, C_P43, C_P1}, '{C_M1, C_M23, C_M1}, '{C_P1, C_M23, C_M1},
        '{C_0, C_P43, C_M1}, '{C_M1, C_M23, C_P1}, '{C_P1, C_M23, C_P1}},
      '{'{C_M78, C_P12, C_P1}, '{C_M78, C_M12, C_M1}, '{C_P78, C_P12, C_P1},
        '{C_P78, C_M12, C_M1}, '{C_0, C_M1, C_P1}, '{C_0, C_P1, C_M1}},
      '{'{C_M12, C_P78, C_P1}, '{C_M12, C_M78, C_P1}, '{C_P12, C_P78, C_M1},
        '{C_P12, C_M78, C_M1}, '{C_M1, C_0, C_M1}, '{C_P1, C_0, C_P1}}
   };

   // shadow of the register file
   frame_type_type cfg_frame;
   logic           cfg_yaw_rev;
   value_type      cfg_min_thr;
   value_type      cfg_max_thr;
   value_type      cfg_min_cmd;
   value_type      cfg_min_check;
   logic           cfg_stop;

   motor_set_t     motor_sets_due[$];
   motor_set_t     seen_set;
   motor_set_t     due_set;

   initial fail_count = 0;

   task automatic report_mismatch(input string msg);
      if (fail_count < MAX_PRINTS)
         $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic int rotor_count(input frame_type_type f);
      case (f)
         FRAME_BI:  return 2;
         FRAME_TRI: return 3;
         FRAME_QUAD_PLUS, FRAME_QUAD_X, FRAME_Y4: return 4;
         default:   return 6;
      endcase
   endfunction

   function automatic int scaled(input int c, input coef_id_t id);
      case (id)
         C_P1:    return c;
         C_M1:    return -c;
         C_P43:   return (c * 4) / 3;
         C_M23:   return (c * -2) / 3;
         C_P78:   return (c * 7) / 8;
         C_M78:   return (c * -7) / 8;
         C_P12:   return c / 2;
         C_M12:   return -c / 2;
         default: return 0;
      endcase
   endfunction

   function automatic int clip(input int a, input int lo, input int hi);
      return (a < lo) ? lo : ((a > hi) ? hi : a);
   endfunction

   // motor values for one control sample under the current registers
   function automatic motor_set_t mix_motors(
      input value_type          thr,
      input logic signed [9:0]  ystick,
      input logic signed [10:0] roll,
      input logic signed [10:0] pitch,
      input logic signed [10:0] yaw,
      input value_type          stick,
      input logic               armed_in
   );
      int         used;
      int         ys;
      int         lim;
      int         y;
      int         peak;
      int         v;
      int         sums [6];
      int         f;
      motor_set_t res;
      f    = int'(cfg_frame);
      used = rotor_count(cfg_frame);
      y    = int'(yaw);
      ys   = int'(ystick);
      // yaw authority limit for four motors and up
      if (used > 3) begin
         lim = 100 + ((ys < 0) ? -ys : ys);
         y   = clip(y, -lim, lim);
      end
      if (cfg_yaw_rev)
         y = -y;
      for (int k = 0; k < 6; k++)
         sums[k] = int'(thr) + scaled(int'(roll), mix_tab[f][k][0])
                 + scaled(int'(pitch), mix_tab[f][k][1]) + scaled(y, mix_tab[f][k][2]);
      peak = sums[0];
      for (int k = 1; k < used; k++)
         if (sums[k] > peak)
            peak = sums[k];
      for (int k = 0; k < 6; k++) begin
         v = 0;
         if (k < used) begin
            v = sums[k];
            // pull everything down by the excess of the hottest motor
            if (peak > int'(cfg_max_thr))
               v = v - (peak - int'(cfg_max_thr));
            v = clip(v, int'(cfg_min_thr), int'(cfg_max_thr));
            if (stick < cfg_min_check)
               v = cfg_stop ? int'(cfg_min_cmd) : int'(cfg_min_thr);
            if (!armed_in)
               v = int'(cfg_min_cmd);
         end
         res[k] = v[10:0];
      end
      return res;
   endfunction

   // watch all three channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         cfg_frame     = FRAME_RESET;
         cfg_yaw_rev   = 1'b0;
         cfg_min_thr   = MIN_THROTTLE_RESET;
         cfg_max_thr   = MAX_THROTTLE_RESET;
         cfg_min_cmd   = MIN_COMMAND_RESET;
         cfg_min_check = MIN_CHECK_RESET;
         cfg_stop      = 1'b0;
         motor_sets_due.delete();
         pending <= 0;
      end else begin
         // sample beat: predict with the registers as they stand now
         if (start && !busy)
            motor_sets_due.push_back(mix_motors(req_throttle_command, req_yaw_stick,
               req_roll_correction, req_pitch_correction, req_yaw_correction,
               req_throttle_stick, req_armed));
         // result beat: compare with the oldest prediction
         if (rsp_strobe) begin
            seen_set = {rsp_motor_5, rsp_motor_4, rsp_motor_3,
                        rsp_motor_2, rsp_motor_1, rsp_motor_0};
            if (motor_sets_due.size() == 0) begin
               report_mismatch("result beat with no sample pending");
            end else begin
               due_set = motor_sets_due.pop_front();
               for (int k = 0; k < 6; k++)
                  if (seen_set[k] !== due_set[k])
                     report_mismatch($sformatf("motor_%0d got %0d expected %0d",
                        k, seen_set[k], due_set[k]));
            end
         end
         // register write beat
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_FRAME_TYPE:        cfg_frame     = frame_type_type'(csr_wdata[2:0]);
               CSR_YAW_REVERSED:      cfg_yaw_rev   = csr_wdata[0];
               CSR_MIN_THROTTLE:      cfg_min_thr   = csr_wdata;
               CSR_MAX_THROTTLE:      cfg_max_thr   = csr_wdata;
               CSR_MIN_COMMAND:       cfg_min_cmd   = csr_wdata;
               CSR_MIN_CHECK:         cfg_min_check = csr_wdata;
               CSR_STOP_AT_LOW_STICK: cfg_stop      = csr_wdata[0];
               default: ;
            endcase
         end
         pending <= motor_sets_due.size();
      end
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   import mmm_pkg::*;

   localparam int LATENCY        = 7;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int NUM_PHASES     = 16;
   localparam int ITEMS_PER_PHASE = 100;

   typedef struct {
      value_type          thr_cmd;
      logic signed [9:0]  yaw_stick;
      logic signed [10:0] roll;
      logic signed [10:0] pitch;
      logic signed [10:0] yaw;
      value_type          thr_stick;
      logic               armed;
   } sample_t;

   logic               clock;
   logic               reset                = 1'b1;
   logic               start                = 1'b0;
   logic               busy;
   value_type          req_throttle_command = '0;
   logic signed [9:0]  req_yaw_stick        = '0;
   logic signed [10:0] req_roll_correction  = '0;
   logic signed [10:0] req_pitch_correction = '0;
   logic signed [10:0] req_yaw_correction   = '0;
   value_type          req_throttle_stick   = '0;
   logic               req_armed            = 1'b0;
   logic               rsp_strobe;
   value_type          rsp_motor_0;
   value_type          rsp_motor_1;
   value_type          rsp_motor_2;
   value_type          rsp_motor_3;
   value_type          rsp_motor_4;
   value_type          rsp_motor_5;
   logic               csr_valid            = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index            = '0;
   value_type          csr_wdata            = '0;

   int                 fail_count;
   int                 pending;
   int                 idle_cycles;
   int                 samples_sent;
   int                 cur_min_check;

   multirotor_motor_mixer i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_throttle_command (req_throttle_command),
      .req_yaw_stick        (req_yaw_stick),
      .req_roll_correction  (req_roll_correction),
      .req_pitch_correction (req_pitch_correction),
      .req_yaw_correction   (req_yaw_correction),
      .req_throttle_stick   (req_throttle_stick),
      .req_armed            (req_armed),
      .rsp_strobe           (rsp_strobe),
      .rsp_motor_0          (rsp_motor_0),
      .rsp_motor_1          (rsp_motor_1),
      .rsp_motor_2          (rsp_motor_2),
      .rsp_motor_3          (rsp_motor_3),
      .rsp_motor_4          (rsp_motor_4),
      .rsp_motor_5          (rsp_motor_5),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   mixer_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_throttle_command (req_throttle_command),
      .req_yaw_stick        (req_yaw_stick),
      .req_roll_correction  (req_roll_correction),
      .req_pitch_correction (req_pitch_correction),
      .req_yaw_correction   (req_yaw_correction),
      .req_throttle_stick   (req_throttle_stick),
      .req_armed            (req_armed),
      .rsp_strobe           (rsp_strobe),
      .rsp_motor_0          (rsp_motor_0),
      .rsp_motor_1          (rsp_motor_1),
      .rsp_motor_2          (rsp_motor_2),
      .rsp_motor_3          (rsp_motor_3),
      .rsp_motor_4          (rsp_motor_4),
      .rsp_motor_5          (rsp_motor_5),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .fail_count           (fail_count),
      .pending              (pending)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: too long without any beat on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no channel activity for %0d cycles", WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic sample_t make_sample(input int thr, input int ystick, input int roll,
                                           input int pitch, input int yaw, input int stick,
                                           input bit armed);
      sample_t s;
      s.thr_cmd   = value_type'(thr);
      s.yaw_stick = 10'(ystick);
      s.roll      = 11'(roll);
      s.pitch     = 11'(pitch);
      s.yaw       = 11'(yaw);
      s.thr_stick = value_type'(stick);
      s.armed     = armed;
      return s;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // signed correction with a random magnitude scale
   function automatic int pick_correction();
      int span;
      span = 1 << $urandom_range(4, 10);
      return int'($urandom_range(0, 2 * span - 1)) - span;
   endfunction

   // flying samples are mostly armed with the stick mostly at or above the idle level; noise is anything
   function automatic sample_t random_sample(input bit flying);
      sample_t s;
      s = make_sample($urandom_range(0, 2047), $urandom_range(0, 1023),
                      $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(0, 2047),
                      1'($urandom_range(0, 1)));
      if (flying) begin
         s.armed = ($urandom_range(0, 19) != 0);
         if ($urandom_range(0, 9) < 7)
            s.thr_cmd = value_type'($urandom_range(900, 2000));
         s.roll  = 11'(pick_correction());
         s.pitch = 11'(pick_correction());
         s.yaw   = 11'(pick_correction());
         if (cur_min_check > 0 && $urandom_range(0, 11) == 0)
            s.thr_stick = value_type'($urandom_range(0, cur_min_check - 1));
         else
            s.thr_stick = value_type'(cur_min_check + $urandom_range(0, 2047 - cur_min_check));
      end
      return s;
   endfunction

   // one sample beat; start stays high when the next one follows without a gap
   task automatic send_sample(input sample_t s, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                <= 1'b1;
      req_throttle_command <= s.thr_cmd;
      req_yaw_stick        <= s.yaw_stick;
      req_roll_correction  <= s.roll;
      req_pitch_correction <= s.pitch;
      req_yaw_correction   <= s.yaw;
      req_throttle_stick   <= s.thr_stick;
      req_armed            <= s.armed;
      do @(posedge clock); while (busy);
      samples_sent++;
   endtask

   // stop sending and let the pipeline empty
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (LATENCY + 3) @(posedge clock);
   endtask

   // register write beat; valid is lowered by the caller after the last one
   task automatic write_csr(input csr_index_type idx, input value_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // program all registers for one phase of the run
   task automatic set_phase(input int p);
      value_type min_thr;
      value_type max_thr;
      value_type min_cmd;
      value_type min_check;
      frame_type_type frame;
      frame   = frame_type_type'(p % 8);
      min_thr = value_type'($urandom_range(1000, 1300));
      max_thr = value_type'($urandom_range(1700, 2000));
      min_cmd = value_type'($urandom_range(900, 1100));
      min_check = value_type'($urandom_range(1000, 1200));
      case (p)
         // widest limits, stick never low
         3: begin
            min_thr = '0; max_thr = 11'd2047; min_cmd = '0; min_check = '0;
         end
         // fully inverted limits, stick low unless at full scale
         7: begin
            min_thr = 11'd2047; max_thr = '0; min_cmd = 11'd2047; min_check = 11'd2047;
         end
         11: begin
            min_thr = value_type'($urandom_range(0, 2047));
            max_thr = value_type'($urandom_range(0, 2047));
            min_cmd = value_type'($urandom_range(0, 2047));
            min_check = value_type'($urandom_range(0, 2047));
         end
         // mildly inverted limits
         12: begin
            min_thr = 11'd1500; max_thr = 11'd1200;
         end
         default: ;
      endcase
      cur_min_check = int'(min_check);
      write_csr(CSR_FRAME_TYPE, value_type'(frame));
      write_csr(CSR_YAW_REVERSED, value_type'($urandom_range(0, 1)));
      write_csr(CSR_MIN_THROTTLE, min_thr);
      write_csr(CSR_MAX_THROTTLE, max_thr);
      write_csr(CSR_MIN_COMMAND, min_cmd);
      write_csr(CSR_MIN_CHECK, min_check);
      write_csr(CSR_STOP_AT_LOW_STICK, value_type'($urandom_range(0, 1)));
      csr_valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      sample_t directed [$];
      samples_sent  = 0;
      cur_min_check = int'(MIN_CHECK_RESET);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed samples under the reset registers (quad x)
      directed.push_back(make_sample(1500, 0, 0, 0, 0, 1500, 1));
      directed.push_back(make_sample(0, -512, -1024, -1024, -1024, 0, 1));
      directed.push_back(make_sample(2047, 511, 1023, 1023, 1023, 2047, 1));
      // yaw limit at its base, and at both stick extremes
      directed.push_back(make_sample(1500, 0, 0, 0, 1023, 1500, 1));
      directed.push_back(make_sample(1500, -512, 0, 0, -1024, 1500, 1));
      directed.push_back(make_sample(1500, 511, 0, 0, 1023, 1500, 1));
      // stick just under and at the idle level
      directed.push_back(make_sample(1500, 0, 0, 0, 0, 1099, 1));
      directed.push_back(make_sample(1500, 0, 0, 0, 0, 1100, 1));
      // disarmed, and disarmed with a low stick
      directed.push_back(make_sample(1500, 0, 300, 0, 0, 1500, 0));
      directed.push_back(make_sample(1500, 0, 0, 0, 0, 0, 0));
      // excess removal and clamp at the low limit
      directed.push_back(make_sample(1840, 0, 200, 100, 50, 2047, 1));
      directed.push_back(make_sample(1000, 0, -300, 200, 0, 2047, 1));
      directed.push_back(make_sample(1023, -1, -1, -1, -1, 1024, 1));
      directed.push_back(make_sample(1024, -256, 512, -512, 341, 1023, 1));
      directed.push_back(make_sample(0, 0, 0, 0, 0, 2047, 1));
      directed.push_back(make_sample(2047, 0, 0, 0, 0, 2047, 1));
      foreach (directed[i])
         send_sample(directed[i], (i % 4 == 3) ? $urandom_range(1, 5) : 0);
      wait_idle();

      // random phases over all frame types and several register settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_phase(p);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_sample(random_sample($urandom_range(0, 9) < 8),
                        ((i / 25) % 2 == 0) ? 0 : pick_gap());
            if ($urandom_range(0, 99) == 0)
               wait_idle();
         end
         wait_idle();
      end

      $display("sent %0d control samples over %0d register settings plus the reset one",
               samples_sent, NUM_PHASES);
      $display("all frame types, both yaw signs, wide, random and inverted limits");
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
